### sv/esh_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// esh_pkg
// Shared widths, register indexes and queue status type for the ELF string
// hash slot core.
// ----------------------------------------------------------------------------
package esh_pkg;

  localparam int BYTE_W   = 8;
  localparam int HASH_W   = 32;
  localparam int SLOT_W   = 21;   // slot_count register width
  localparam int IDX_W    = 20;   // slot_index output width
  localparam int CFG_IX_W = 2;
  localparam int STEP_W   = $clog2(HASH_W);

  // Configuration register indexes
  localparam logic [CFG_IX_W-1:0] CFG_SLOT_COUNT  = 2'd0;
  localparam logic [CFG_IX_W-1:0] CFG_SIGN_EXTEND = 2'd1;

  localparam logic [SLOT_W-1:0] SLOT_COUNT_RST = 21'd256;

  // Status of the hash queue between front and back
  typedef struct packed {
    logic full;
    logic empty;
  } esh_qstat_t;

endpackage

### sv/esh_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// esh_front
// Byte intake: one ELF hash update per accepted nonzero byte; a zero byte
// pushes the finished hash into the queue and clears the accumulator.
// ----------------------------------------------------------------------------
module esh_front (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           sign_extend,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [esh_pkg::BYTE_W-1:0]     in_char_byte,
  input  esh_pkg::esh_qstat_t            q_stat,
  output logic                           q_push,
  output logic [esh_pkg::HASH_W-1:0]     q_wdata
);

  logic [esh_pkg::HASH_W-1:0] acc_r;
  logic [esh_pkg::HASH_W-1:0] acc_nxt;
  logic [esh_pkg::HASH_W-1:0] byte_wide;
  logic [esh_pkg::HASH_W-1:0] sum;
  logic [3:0]                 top;
  logic                       accept;

  assign in_stall = q_stat.full;
  assign accept   = in_valid && !in_stall;
  assign q_push   = accept && (in_char_byte == '0);
  assign q_wdata  = acc_r;

  // Widen, shift-add, then fold the top nibble down into bits 7:4 and clear it
  always_comb begin
    byte_wide = {{(esh_pkg::HASH_W-esh_pkg::BYTE_W){sign_extend && in_char_byte[7]}},
                 in_char_byte};
    sum       = {acc_r[esh_pkg::HASH_W-5:0], 4'b0000} + byte_wide;
    top       = sum[esh_pkg::HASH_W-1 -: 4];
    acc_nxt   = {4'b0000, sum[esh_pkg::HASH_W-5:0] ^ {20'd0, top, 4'b0000}};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= '0;
    end else if (accept) begin
      if (in_char_byte == '0) begin
        acc_r <= '0;
      end else begin
        acc_r <= acc_nxt;
      end
    end
  end

endmodule

### sv/esh_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// esh_queue
// Short FIFO of finished hashes between the byte intake and the reducer.
// ----------------------------------------------------------------------------
module esh_queue #(
  parameter int DEPTH = 4
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           push,
  input  logic [esh_pkg::HASH_W-1:0]     wdata,
  input  logic                           pop,
  output logic [esh_pkg::HASH_W-1:0]     rdata,
  output esh_pkg::esh_qstat_t            stat
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [esh_pkg::HASH_W-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0]           wr_ptr_r;
  logic [PTR_W-1:0]           rd_ptr_r;
  logic [CNT_W-1:0]           cnt_r;
  logic [CNT_W-1:0]           cnt_nxt;

  assign stat.full  = (cnt_r == CNT_W'(DEPTH));
  assign stat.empty = (cnt_r == '0);
  assign rdata      = mem_r[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH-1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH-1)) ? '0 : rd_ptr_r + 1'b1;
      end
    end
  end

endmodule

### sv/esh_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// esh_back
// Slot reducer: restoring remainder, one quotient bit per cycle, then an
// output register toward the result channel.
// ----------------------------------------------------------------------------
module esh_back (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic [esh_pkg::SLOT_W-1:0]     slot_count,
  input  esh_pkg::esh_qstat_t            q_stat,
  input  logic [esh_pkg::HASH_W-1:0]     q_rdata,
  output logic                           q_pop,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [esh_pkg::IDX_W-1:0]      out_slot_index,
  output logic [esh_pkg::HASH_W-1:0]     out_raw_hash
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV  = 2'd1;
  localparam logic [1:0] ST_LOAD = 2'd2;

  logic [1:0]                    state_r;
  logic [1:0]                    state_nxt;
  logic [esh_pkg::HASH_W-1:0]    dvd_r;
  logic [esh_pkg::HASH_W-1:0]    raw_r;
  logic [esh_pkg::SLOT_W-1:0]    div_r;
  logic [esh_pkg::SLOT_W-1:0]    rem_r;
  logic [esh_pkg::SLOT_W-1:0]    rem_nxt;
  logic [esh_pkg::STEP_W-1:0]    step_r;
  logic [esh_pkg::SLOT_W:0]      trial;
  logic                          out_valid_r;
  logic [esh_pkg::IDX_W-1:0]     out_slot_r;
  logic [esh_pkg::HASH_W-1:0]    out_hash_r;
  logic                          out_free;
  logic                          load;

  assign out_free       = !out_valid_r || !out_stall;
  assign q_pop          = (state_r == ST_IDLE) && !q_stat.empty;
  assign load           = (state_r == ST_LOAD) && out_free;
  assign out_valid      = out_valid_r;
  assign out_slot_index = out_slot_r;
  assign out_raw_hash   = out_hash_r;

  // One restoring step: bring down the next dividend bit, subtract if it fits
  always_comb begin
    trial = {rem_r, dvd_r[esh_pkg::HASH_W-1]};
    if (trial >= {1'b0, div_r}) begin
      rem_nxt = esh_pkg::SLOT_W'(trial - {1'b0, div_r});
    end else begin
      rem_nxt = trial[esh_pkg::SLOT_W-1:0];
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (q_pop) state_nxt = ST_DIV;
      end
      ST_DIV: begin
        if (step_r == esh_pkg::STEP_W'(esh_pkg::HASH_W-1)) state_nxt = ST_LOAD;
      end
      ST_LOAD: begin
        if (out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      dvd_r  <= q_rdata;
      raw_r  <= q_rdata;
      div_r  <= slot_count;
      rem_r  <= '0;
      step_r <= '0;
    end else if (state_r == ST_DIV) begin
      dvd_r  <= {dvd_r[esh_pkg::HASH_W-2:0], 1'b0};
      rem_r  <= rem_nxt;
      step_r <= step_r + 1'b1;
    end
    if (load) begin
      out_slot_r <= (div_r == '0) ? '0 : rem_r[esh_pkg::IDX_W-1:0];
      out_hash_r <= raw_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

endmodule

### sv/elf_string_hash_slot_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// elf_string_hash_slot_core
// ELF/PJW 32-bit string hash with reduction to a configurable slot count.
// ----------------------------------------------------------------------------
//
//  Channel | Direction | Handshake          | Payload
//  --------+-----------+--------------------+-------------------------------
//  in_     | input     | in_valid/in_stall  | in_char_byte[7:0]
//  out_    | output    | out_valid/out_stall| out_slot_index[19:0],
//          |           |                    | out_raw_hash[31:0]
//  cfg_    | input     | cfg_valid/cfg_ready| cfg_index[1:0], cfg_wdata[20:0]
//
//  Bytes enter at one per cycle unless in_stall holds them: the intake folds
//  each byte into the hash in the cycle it is accepted. A zero byte hands the
//  hash to a QUEUE_DEPTH-entry queue; the reducer pops it and takes each string
//  through a pop, 32 remainder steps and a load of the output register, so
//  short strings fill the queue, and in_stall rises while it is full.
//  Reset is synchronous on rst_n low; it clears the accumulator, queue,
//  reducer state and the registers to slot_count 256, sign extension on.
//  cfg_ready is always high; write configuration only while the core is idle.
//
module elf_string_hash_slot_core #(
  parameter int QUEUE_DEPTH = 4   // range 2 and up
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // byte channel
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [esh_pkg::BYTE_W-1:0]         in_char_byte,
  // result channel
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [esh_pkg::IDX_W-1:0]          out_slot_index,
  output logic [esh_pkg::HASH_W-1:0]         out_raw_hash,
  // configuration write channel
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [esh_pkg::CFG_IX_W-1:0]       cfg_index,
  input  logic [esh_pkg::SLOT_W-1:0]         cfg_wdata
);

  logic [esh_pkg::SLOT_W-1:0] slot_count_r;
  logic                       sign_ext_r;
  esh_pkg::esh_qstat_t        q_stat;
  logic                       q_push;
  logic                       q_pop;
  logic [esh_pkg::HASH_W-1:0] q_wdata;
  logic [esh_pkg::HASH_W-1:0] q_rdata;

  // Configuration registers: every write is accepted at once and registered
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_count_r <= esh_pkg::SLOT_COUNT_RST;
      sign_ext_r   <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        esh_pkg::CFG_SLOT_COUNT:  slot_count_r <= cfg_wdata;
        esh_pkg::CFG_SIGN_EXTEND: sign_ext_r   <= cfg_wdata[0];
        default: ;  // drop writes to unused indexes
      endcase
    end
  end

  // Front: hash bytes, push finished strings
  esh_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .sign_extend  (sign_ext_r),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_char_byte (in_char_byte),
    .q_stat       (q_stat),
    .q_push       (q_push),
    .q_wdata      (q_wdata)
  );

  // Queue: hold finished hashes so intake and reduction stall independently
  esh_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .pop   (q_pop),
    .rdata (q_rdata),
    .stat  (q_stat)
  );

  // Back: reduce modulo slot_count (a zero count gives slot 0) and present the result
  esh_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .slot_count     (slot_count_r),
    .q_stat         (q_stat),
    .q_rdata        (q_rdata),
    .q_pop          (q_pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_slot_index (out_slot_index),
    .out_raw_hash   (out_raw_hash)
  );

endmodule

### bench/esh_hash_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// esh_hash_checker
// Watches the byte, result and register channels of the string hash core,
// folds every accepted nonzero byte into its own copy of the hash and compares each
// delivered result with the oldest string still owed.
// ----------------------------------------------------------------------------
module esh_hash_checker (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  input  logic                                in_stall,
  input  logic [esh_pkg::BYTE_W-1:0]          in_char_byte,
  input  logic                                out_valid,
  input  logic                                out_stall,
  input  logic [esh_pkg::IDX_W-1:0]           out_slot_index,
  input  logic [esh_pkg::HASH_W-1:0]          out_raw_hash,
  input  logic                                cfg_valid,
  input  logic                                cfg_ready,
  input  logic [esh_pkg::CFG_IX_W-1:0]        cfg_index,
  input  logic [esh_pkg::SLOT_W-1:0]          cfg_wdata,
  output int                                  fail_count,
  output int                                  pending
);

  localparam logic [esh_pkg::HASH_W-1:0] TOP_NIBBLE = 32'hF000_0000;
  localparam int                         FOLD_SHIFT = 24;
  localparam int                         STEP_SHIFT = 4;
  localparam logic [esh_pkg::BYTE_W-1:0] STR_END    = 8'h00;

  typedef struct packed {
    logic [esh_pkg::IDX_W-1:0]  slot;
    logic [esh_pkg::HASH_W-1:0] raw;
  } string_hash_t;

  string_hash_t               owed_hashes[$];
  logic [esh_pkg::HASH_W-1:0] hash_acc;
  logic [esh_pkg::SLOT_W-1:0] slot_count;
  logic                       sign_ext;
  int                         errs = 0;

  function automatic logic [esh_pkg::HASH_W-1:0] pjw_fold(
      logic [esh_pkg::HASH_W-1:0] h, logic [esh_pkg::BYTE_W-1:0] c, logic sx);
    logic [esh_pkg::HASH_W-1:0] wide;
    logic [esh_pkg::HASH_W-1:0] top;
    logic [esh_pkg::HASH_W-1:0] nh;
    wide = (sx && c[esh_pkg::BYTE_W-1]) ?
           {{(esh_pkg::HASH_W-esh_pkg::BYTE_W){1'b1}}, c} :
           {{(esh_pkg::HASH_W-esh_pkg::BYTE_W){1'b0}}, c};
    nh   = (h << STEP_SHIFT) + wide;
    top  = nh & TOP_NIBBLE;
    if (top != '0) nh = (nh ^ (top >> FOLD_SHIFT)) & ~TOP_NIBBLE;
    return nh;
  endfunction

  function automatic logic [esh_pkg::IDX_W-1:0] slot_of(logic [esh_pkg::HASH_W-1:0] h,
                                                        logic [esh_pkg::SLOT_W-1:0] n);
    logic [esh_pkg::HASH_W-1:0] rem;
    if (n == '0) return '0;
    rem = h % {{(esh_pkg::HASH_W-esh_pkg::SLOT_W){1'b0}}, n};
    return rem[esh_pkg::IDX_W-1:0];
  endfunction

  always @(posedge clk) begin : watch
    string_hash_t want;
    if (!rst_n) begin
      hash_acc   = '0;
      slot_count = esh_pkg::SLOT_COUNT_RST;
      sign_ext   = 1'b1;
      owed_hashes.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (owed_hashes.size() == 0) begin
          $error("result with no string owed: slot_index %0d raw_hash %h",
                 out_slot_index, out_raw_hash);
          errs++;
        end else begin
          want = owed_hashes.pop_front();
          if (out_slot_index !== want.slot) begin
            $error("slot_index mismatch: expected %0d, actual %0d", want.slot, out_slot_index);
            errs++;
          end
          if (out_raw_hash !== want.raw) begin
            $error("raw_hash mismatch: expected %h, actual %h", want.raw, out_raw_hash);
            errs++;
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          esh_pkg::CFG_SLOT_COUNT:  slot_count = cfg_wdata;
          esh_pkg::CFG_SIGN_EXTEND: sign_ext   = cfg_wdata[0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        if (in_char_byte != STR_END) begin
          hash_acc = pjw_fold(hash_acc, in_char_byte, sign_ext);
        end else begin
          want.raw  = hash_acc;
          want.slot = slot_of(hash_acc, slot_count);
          owed_hashes.push_back(want);
          hash_acc  = '0;
        end
      end
    end
    fail_count <= errs;
    pending    <= owed_hashes.size();
  end

endmodule

### bench/elf_string_hash_slot_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// elf_string_hash_slot_core_tb
// Drives strings into the ELF hash slot core under several slot counts and
// both byte sign modes, with random idle cycles on both channels, a long
// result hold-off and a full drain; a checker beside the core predicts and
// compares every result, and this top reports the verdict.
// ----------------------------------------------------------------------------
module elf_string_hash_slot_core_tb;

  localparam logic [esh_pkg::BYTE_W-1:0] STR_END     = 8'h00;
  localparam int                         IDLE_PCT    = 19;
  localparam int                         SETTLE_CYC  = 64;   // about two reducer passes
  localparam int                         HOLD_CYC    = 400;
  localparam int                         PHASE_ITEMS = 150;
  localparam int                         N_PHASES    = 7;

  logic                         clk;
  logic                         rst_n          = 1'b0;
  logic                         in_valid       = 1'b0;
  logic                         in_stall;
  logic [esh_pkg::BYTE_W-1:0]   in_char_byte   = '0;
  logic                         out_valid;
  logic                         out_stall      = 1'b0;
  logic [esh_pkg::IDX_W-1:0]    out_slot_index;
  logic [esh_pkg::HASH_W-1:0]   out_raw_hash;
  logic                         cfg_valid      = 1'b0;
  logic                         cfg_ready;
  logic [esh_pkg::CFG_IX_W-1:0] cfg_index      = '0;
  logic [esh_pkg::SLOT_W-1:0]   cfg_wdata      = '0;

  int fail_count;
  int pending;
  int items_sent = 0;

  // Shared knobs: stimulus sets quiet/hold_req for the result sink, which sets hold_done
  bit quiet    = 1'b0;
  bit hold_req = 1'b0;
  bit hold_done = 1'b0;

  elf_string_hash_slot_core dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_char_byte   (in_char_byte),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_slot_index (out_slot_index),
    .out_raw_hash   (out_raw_hash),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata)
  );

  esh_hash_checker chk (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_char_byte   (in_char_byte),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_slot_index (out_slot_index),
    .out_raw_hash   (out_raw_hash),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .fail_count     (fail_count),
    .pending        (pending)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Hard stop well past the slowest legal run, even with every string paying the
  // full reducer pass.
  initial begin
    #2000000;
    $display("end of test: mismatches");
    $finish;
  end

  // Result sink: random stalls, one long hold-off on request, and no
  // stalls at all while the quiet window is open.
  initial begin : result_sink
    int n;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        out_stall <= 1'b1;
        // count the hold-off here; the stall stays high throughout
        for (n = 1; n < HOLD_CYC; n++) @(posedge clk);
      end else begin
        out_stall <= !quiet && ($urandom_range(0, 99) < IDLE_PCT);
      end
    end
  end

  // Offer one byte transaction, idling at random first; hold the payload
  // while the core stalls. Valid is left high so back-to-back bytes keep it up.
  task automatic send_byte(input logic [esh_pkg::BYTE_W-1:0] b);
    while (!quiet && ($urandom_range(0, 99) < IDLE_PCT)) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_char_byte <= b;
    do @(posedge clk); while (in_stall);
    items_sent++;
  endtask

  function automatic logic [esh_pkg::BYTE_W-1:0] pick_char();
    case ($urandom_range(0, 3))
      0:       return esh_pkg::BYTE_W'($urandom_range(1, 127));
      1:       return esh_pkg::BYTE_W'($urandom_range(128, 255));
      default: return esh_pkg::BYTE_W'($urandom_range(1, 255));
    endcase
  endfunction

  task automatic send_string(input int len);
    int i;
    for (i = 0; i < len; i++) send_byte(pick_char());
    send_byte(STR_END);
  endtask

  // Drop valid, wait for every owed result, then let the reducer settle.
  // The first edge lets the checker's count catch the last terminator.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  // Register write transaction; the caller drops cfg_valid after the group.
  task automatic cfg_write(input logic [esh_pkg::CFG_IX_W-1:0] ix,
                           input logic [esh_pkg::SLOT_W-1:0] d);
    cfg_valid <= 1'b1;
    cfg_index <= ix;
    cfg_wdata <= d;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic set_regs(input logic [esh_pkg::SLOT_W-1:0] slots, input logic sx);
    logic [esh_pkg::SLOT_W-1:0] junk;
    junk    = esh_pkg::SLOT_W'($urandom);
    junk[0] = sx;
    cfg_write(esh_pkg::CFG_SLOT_COUNT, slots);
    cfg_write(esh_pkg::CFG_SIGN_EXTEND, junk);   // upper bits must be ignored
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Mostly well-formed strings; the rest is raw noise with stray
  // terminators, which splices fragments into the following string.
  task automatic run_random(input int n_items);
    int stop;
    int len;
    int k;
    int i;
    stop = items_sent + n_items;
    while (items_sent < stop) begin
      if ($urandom_range(0, 99) < 80) begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(0, 12);
        send_string(len);
      end else begin
        k = $urandom_range(1, 8);
        for (i = 0; i < k; i++)
          send_byte(($urandom_range(0, 3) == 0) ? STR_END :
                    esh_pkg::BYTE_W'($urandom_range(1, 255)));
      end
    end
    // close any open fragment so no partial hash spans a register write
    send_byte(STR_END);
  endtask

  initial begin : stimulus
    logic [esh_pkg::SLOT_W-1:0] slot_tab [N_PHASES];
    logic                       sign_tab [N_PHASES];
    int p;

    slot_tab[0] = 21'd1;        sign_tab[0] = 1'b0;
    slot_tab[1] = 21'd0;        sign_tab[1] = 1'b1;   // zero count: slot_index forced to 0
    slot_tab[2] = 21'd1048576;  sign_tab[2] = 1'b0;
    slot_tab[3] = 21'd2097151;  sign_tab[3] = 1'b1;   // above the nominal range
    slot_tab[4] = esh_pkg::SLOT_W'($urandom_range(2, 4096));
    sign_tab[4] = 1'($urandom_range(0, 1));
    slot_tab[5] = esh_pkg::SLOT_W'($urandom_range(1048577, 2097151));
    sign_tab[5] = 1'($urandom_range(0, 1));
    slot_tab[6] = esh_pkg::SLOT_W'($urandom_range(1, 1048576));
    sign_tab[6] = 1'($urandom_range(0, 1));

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed, reset settings: empty strings back to back, single bytes
    // at the edges of the signed range, then a run long enough to fold.
    send_byte(STR_END);
    send_byte(STR_END);
    send_byte(8'hFF); send_byte(STR_END);
    send_byte(8'h80); send_byte(STR_END);
    send_byte(8'h7F); send_byte(STR_END);
    send_byte(8'h01); send_byte(STR_END);
    repeat (8) send_byte(8'hFF);
    send_byte(STR_END);
    drain();

    // Same high bytes read as unsigned
    set_regs(esh_pkg::SLOT_COUNT_RST, 1'b0);
    send_byte(8'h80); send_byte(8'hFF); send_byte(STR_END);
    drain();

    for (p = 0; p < N_PHASES; p++) begin
      set_regs(slot_tab[p], sign_tab[p]);
      if (p == 2) begin
        // unused indexes: the core must leave both registers alone
        cfg_write(2'd2, esh_pkg::SLOT_W'($urandom));
        cfg_write(2'd3, esh_pkg::SLOT_W'($urandom));
        cfg_valid <= 1'b0;
        @(posedge clk);
      end
      case (p)
        1: begin
          // hold off the sink and keep feeding short strings until the
          // queue backs up and the core stalls its input
          hold_req = 1'b1;
          repeat (30) send_string($urandom_range(0, 2));
          run_random(PHASE_ITEMS - 50);
        end
        3: begin
          run_random(PHASE_ITEMS / 2);
          drain();
          run_random(PHASE_ITEMS / 2);
        end
        4: begin
          quiet = 1'b1;
          run_random(PHASE_ITEMS);
          quiet = 1'b0;
        end
        default: run_random(PHASE_ITEMS);
      endcase
      drain();
    end

    if (fail_count == 0 && pending == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
